// ----- src/tdh_pkg.sv -----
// shared types, constants and helpers of the timer deadline heap
package tdh_pkg;

  localparam int HEAP_SLOTS = 64;
  localparam int SWEEP_MAX  = 64;
  localparam int SLOT_W     = $clog2(HEAP_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int LIM_W      = 7;
  localparam int DL_W       = 48;
  localparam int ID_W       = 32;
  localparam int FLOW_W     = 16;
  localparam int KIND_W     = 3;
  localparam int STAT_W     = 3;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REARM  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SWEEP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFND  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REJECT  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FIRED   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOTHING = 3'd5;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(SWEEP_MAX);

  typedef struct packed {
    logic [DL_W-1:0]   dl;
    logic [DL_W-1:0]   iv;
    logic [ID_W-1:0]   id;
    logic [FLOW_W-1:0] flow;
    logic              inl;
    logic              rep;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [FLOW_W-1:0] flow;
    logic              inl;
    logic              wake;
    logic [DL_W-1:0]   dl;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ROOT, S_SCAN, S_TAIL, S_UP_ISS, S_UP, S_DN_ISS,
    S_DN_L, S_DN_R, S_PLACE, S_RESP, S_SW_CHK, S_SW_ROOT
  } state_e;

  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                              input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
  endfunction

endpackage

// ----- src/tdh_cmd_if.sv -----
// command channel of the timer deadline heap
interface tdh_cmd_if import tdh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [DL_W-1:0]          now;
  logic signed [DL_W-1:0]   delay;
  logic [ID_W-1:0]          timer_id;
  logic [FLOW_W-1:0]        flow_id;
  logic                     repeat_req;
  logic                     inline_callback;

  modport source (output valid, kind, now, delay, timer_id, flow_id, repeat_req,
                  inline_callback, input ready);
  modport sink (input valid, kind, now, delay, timer_id, flow_id, repeat_req,
                inline_callback, output ready);
endinterface

// ----- src/tdh_res_if.sv -----
// result channel of the timer deadline heap
interface tdh_res_if import tdh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     result_id;
  logic [FLOW_W-1:0]   result_flow;
  logic                result_inline;
  logic                wake_needed;
  logic [DL_W-1:0]     deadline_out;
  logic                last;

  modport source (output valid, status, result_id, result_flow, result_inline,
                  wake_needed, deadline_out, last, input ready);
  modport sink (input valid, status, result_id, result_flow, result_inline,
                wake_needed, deadline_out, last, output ready);
endinterface

// ----- src/tdh_ram.sv -----
// generic single-port-write, registered-read ram
module tdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- src/timer_deadline_heap_core.sv -----
// timer queue kept as a binary min-heap on deadline in one entry ram
// One command item is taken at a time. The heap lives in a 64-entry ram with
// one read and one write per cycle, so cost is set by that port. An add reads
// the root, rises one level at a time while its parent is later, then checks
// the children of its final slot. A sift down reads the left and, if present,
// the right child per level moved; a heap of 64 entries has at most 7 levels.
// Cancel and rearm first scan the occupied slots at one slot per cycle, then
// sift. A sweep looks at the root and sinks the replacement of each fired
// timer. A result item sits in an output register, so the next command is
// taken while it waits. The user is to write the sweep limit register only
// between sweeps, for the next sweep command; the block does not enforce it.
module timer_deadline_heap_core import tdh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tdh_cmd_if.sink           cmd,
  tdh_res_if.source         res,
  input  logic              cfg_we_i,
  input  logic [LIM_W-1:0]  cfg_wdata_i
);
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ID_W-1:0]    serial_q, serial_d;
  logic [LIM_W-1:0]   lim_q;
  logic [KIND_W-1:0]  kind_q;
  logic [DL_W-1:0]    now_q, dly_q;
  logic [ID_W-1:0]    tid_q;
  logic [FLOW_W-1:0]  flow_q;
  logic               rep_q, inl_q;
  ent_t               cur_q, cur_d, kid_q, kid_d;
  logic [SLOT_W-1:0]  hole_q, hole_d, ra_q, ra_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic [LIM_W-1:0]   fired_q, fired_d;
  logic               wake_q, wake_d, pend_q, pend_d;
  logic [DL_W-1:0]    root_q, root_d;
  res_t               rs_q, rs_d, pres_q, pres_d, out_q, out_d;
  logic               out_vld_q, out_vld_d;

  logic               we;
  logic [SLOT_W-1:0]  wa;
  ent_t               wd;
  logic [ENT_W-1:0]   rdata;
  ent_t               rd;

  logic               accept, out_free, hit, scan_end, up_move, kid_in, kidr_in;
  logic               right_sel, dn_move_l, dn_move_r, sw_go, due, fire_stall;
  logic [CNT_W-1:0]   ci, kidx, kidr, last_idx;
  logic [SLOT_W-1:0]  par;
  logic [LIM_W-1:0]   lim_eff;
  logic [DL_W-1:0]    dl_new, rep_nx, rep_sum, now_p1, root_dl;
  ent_t               sel;
  logic [SLOT_W-1:0]  sel_idx;
  logic [ID_W-1:0]    serial_nx;

  tdh_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i (wd),
    .raddr_i (ra_d),
    .rdata_o (rdata)
  );

  assign rd        = ent_t'(rdata);
  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state_q == S_IDLE);
  assign out_free  = !out_vld_q || res.ready;

  assign dl_new    = sat_add(now_q, dly_q);
  assign serial_nx = (serial_q + 1'b1 == '0) ? ID_W'(1) : serial_q + 1'b1;
  assign ci        = scan_q - 1'b1;
  assign hit       = (rd.id == tid_q);
  assign scan_end  = (scan_q == cnt_q);
  assign last_idx  = cnt_q - 1'b1;
  assign root_dl   = (ci == '0) ? rd.dl : root_q;
  assign par       = (hole_q - 1'b1) >> 1;
  assign up_move   = rd.dl > cur_q.dl;
  assign kidx      = {hole_q, 1'b1};
  assign kidr      = kidx + 1'b1;
  assign kid_in    = kidx < cnt_q;
  assign kidr_in   = kidr < cnt_q;
  assign dn_move_l = cur_q.dl > rd.dl;
  assign right_sel = rd.dl < kid_q.dl;
  assign sel       = right_sel ? rd : kid_q;
  assign sel_idx   = right_sel ? kidr[SLOT_W-1:0] : kidx[SLOT_W-1:0];
  assign dn_move_r = cur_q.dl > sel.dl;
  assign lim_eff   = (lim_q == '0) ? LIM_W'(1) :
                     (lim_q > LIM_W'(SWEEP_MAX)) ? LIM_W'(SWEEP_MAX) : lim_q;
  assign sw_go     = (fired_q < lim_eff) && (cnt_q != '0);
  assign due       = rd.dl <= now_q;
  assign fire_stall = due && pend_q && !out_free;
  assign rep_sum   = sat_add(rd.dl, rd.iv);
  assign now_p1    = sat_add(now_q, DL_W'(1));
  assign rep_nx    = (rep_sum <= now_q) ? now_p1 : rep_sum;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DEC;
      S_DEC: begin
        unique case (kind_q)
          KIND_ADD: begin
            if (flow_q == '0 || cnt_q == CNT_W'(HEAP_SLOTS)) state_d = S_RESP;
            else if (cnt_q == '0) state_d = S_UP_ISS;
            else state_d = S_ROOT;
          end
          KIND_CANCEL, KIND_REARM: begin
            state_d = (tid_q == '0 || cnt_q == '0) ? S_RESP : S_SCAN;
          end
          KIND_SWEEP: state_d = S_SW_CHK;
          KIND_QUERY: state_d = (cnt_q == '0) ? S_RESP : S_ROOT;
          default:    state_d = S_RESP;
        endcase
      end
      S_ROOT: state_d = (kind_q == KIND_ADD) ? S_UP_ISS : S_RESP;
      S_SCAN: begin
        if (hit) begin
          if (kind_q == KIND_REARM) state_d = S_UP_ISS;
          else if (ci < last_idx) state_d = S_TAIL;
          else state_d = S_RESP;
        end else if (scan_end) begin
          state_d = S_RESP;
        end
      end
      S_TAIL:   state_d = S_UP_ISS;
      S_UP_ISS: state_d = (hole_q == '0) ? S_DN_ISS : S_UP;
      S_UP: begin
        if (!up_move || par == '0) state_d = S_DN_ISS;
      end
      S_DN_ISS: state_d = kid_in ? S_DN_L : S_PLACE;
      S_DN_L: begin
        if (kidr_in) state_d = S_DN_R;
        else state_d = dn_move_l ? S_DN_ISS : S_PLACE;
      end
      S_DN_R:  state_d = dn_move_r ? S_DN_ISS : S_PLACE;
      S_PLACE: state_d = (kind_q == KIND_SWEEP) ? S_SW_CHK : S_RESP;
      S_RESP:  if (out_free) state_d = S_IDLE;
      S_SW_CHK: state_d = sw_go ? S_SW_ROOT : S_RESP;
      S_SW_ROOT: begin
        if (!due) state_d = S_RESP;
        else if (!fire_stall) begin
          if (rd.rep) state_d = S_DN_ISS;
          else state_d = (cnt_q > CNT_W'(1)) ? S_TAIL : S_SW_CHK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    serial_d  = serial_q;
    cur_d     = cur_q;
    kid_d     = kid_q;
    hole_d    = hole_q;
    ra_d      = ra_q;
    scan_d    = scan_q;
    fired_d   = fired_q;
    wake_d    = wake_q;
    pend_d    = pend_q;
    root_d    = root_q;
    rs_d      = rs_q;
    pres_d    = pres_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !res.ready;
    we        = 1'b0;
    wa        = hole_q;
    wd        = rd;
    unique case (state_q)
      S_DEC: begin
        rs_d = '{status: STAT_REJECT, last: 1'b1, default: '0};
        unique case (kind_q)
          KIND_ADD: begin
            if (flow_q != '0 && cnt_q == CNT_W'(HEAP_SLOTS)) begin
              rs_d.status = STAT_FULL;
            end else if (flow_q != '0) begin
              serial_d = serial_nx;
              cur_d    = '{dl: dl_new, iv: dly_q, id: serial_nx, flow: flow_q,
                           inl: inl_q, rep: rep_q};
              hole_d   = cnt_q[SLOT_W-1:0];
              cnt_d    = cnt_q + 1'b1;
              wake_d   = 1'b1;
              ra_d     = '0;
            end
          end
          KIND_CANCEL, KIND_REARM: begin
            rs_d.status = STAT_NOTFND;
            ra_d        = '0;
            scan_d      = CNT_W'(1);
          end
          KIND_SWEEP: begin
            fired_d = '0;
            pend_d  = 1'b0;
          end
          KIND_QUERY: begin
            rs_d.status = STAT_OK;
            ra_d        = '0;
          end
          default: ;
        endcase
      end
      S_ROOT: begin
        wake_d    = dl_new < rd.dl;
        rs_d.dl   = rd.dl;
      end
      S_SCAN: begin
        ra_d   = scan_q[SLOT_W-1:0];
        scan_d = scan_q + 1'b1;
        if (ci == '0) root_d = rd.dl;
        if (hit) begin
          hole_d      = ci[SLOT_W-1:0];
          rs_d.status = STAT_OK;
          if (kind_q == KIND_REARM) begin
            wake_d   = dl_new < root_dl;
            cur_d    = rd;
            cur_d.dl = dl_new;
            cur_d.iv = dly_q;
          end else begin
            cnt_d = last_idx;
            ra_d  = last_idx[SLOT_W-1:0];
          end
        end
      end
      S_TAIL: cur_d = rd;
      S_UP_ISS: ra_d = par;
      S_UP: begin
        if (up_move) begin
          we     = 1'b1;
          hole_d = par;
          ra_d   = (par - 1'b1) >> 1;
        end
      end
      S_DN_ISS: ra_d = kidx[SLOT_W-1:0];
      S_DN_L: begin
        kid_d = rd;
        if (kidr_in) begin
          ra_d = kidr[SLOT_W-1:0];
        end else if (dn_move_l) begin
          we     = 1'b1;
          hole_d = kidx[SLOT_W-1:0];
        end
      end
      S_DN_R: begin
        if (dn_move_r) begin
          we     = 1'b1;
          wd     = sel;
          hole_d = sel_idx;
        end
      end
      S_PLACE: begin
        we   = 1'b1;
        wd   = cur_q;
        rs_d = '{status: STAT_OK, last: 1'b1, default: '0};
        if (kind_q != KIND_CANCEL) rs_d.wake = wake_q;
        if (kind_q == KIND_ADD) rs_d.id = serial_q;
      end
      S_RESP: begin
        if (out_free) begin
          out_d     = rs_q;
          out_vld_d = 1'b1;
        end
      end
      S_SW_CHK: begin
        ra_d = '0;
        if (pend_q) begin
          rs_d      = pres_q;
          rs_d.last = 1'b1;
        end else begin
          rs_d = '{status: STAT_NOTHING, last: 1'b1, default: '0};
        end
      end
      S_SW_ROOT: begin
        if (due && !fire_stall) begin
          if (pend_q) begin
            out_d     = pres_q;
            out_vld_d = 1'b1;
          end
          pend_d  = 1'b1;
          pres_d  = '{status: STAT_FIRED, id: rd.id, flow: rd.flow, inl: rd.inl,
                      default: '0};
          fired_d = fired_q + 1'b1;
          hole_d  = '0;
          if (rd.rep) begin
            cur_d    = rd;
            cur_d.dl = rep_nx;
          end else begin
            cnt_d = last_idx;
            ra_d  = last_idx[SLOT_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      serial_q  <= '0;
      lim_q     <= LIM_RESET;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      ra_q      <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      serial_q  <= serial_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
      ra_q      <= ra_d;
      if (cfg_we_i) lim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= cmd.kind;
      now_q  <= cmd.now;
      dly_q  <= cmd.delay[DL_W-1] ? '0 : DL_W'(cmd.delay);
      tid_q  <= cmd.timer_id;
      flow_q <= cmd.flow_id;
      rep_q  <= cmd.repeat_req;
      inl_q  <= cmd.inline_callback;
    end
    cur_q   <= cur_d;
    kid_q   <= kid_d;
    hole_q  <= hole_d;
    scan_q  <= scan_d;
    fired_q <= fired_d;
    wake_q  <= wake_d;
    root_q  <= root_d;
    rs_q    <= rs_d;
    pres_q  <= pres_d;
    out_q   <= out_d;
  end

  assign res.valid         = out_vld_q;
  assign res.status        = out_q.status;
  assign res.result_id     = out_q.id;
  assign res.result_flow   = out_q.flow;
  assign res.result_inline = out_q.inl;
  assign res.wake_needed   = out_q.wake;
  assign res.deadline_out  = out_q.dl;
  assign res.last          = out_q.last;
endmodule

// ----- tb/sv/tb_top.sv -----
// testbench of the timer deadline heap: random commands checked against a heap predictor
`timescale 1ns / 100ps
module tb_top;
  import tdh_pkg::*;

  class heap_scoreboard;
    logic [DL_W-1:0]   h_dl[HEAP_SLOTS];
    logic [DL_W-1:0]   h_iv[HEAP_SLOTS];
    logic [ID_W-1:0]   h_id[HEAP_SLOTS];
    logic [FLOW_W-1:0] h_flow[HEAP_SLOTS];
    logic              h_rep[HEAP_SLOTS];
    logic              h_inl[HEAP_SLOTS];
    int                count;
    logic [ID_W-1:0]   serial;
    logic [LIM_W-1:0]  limit;
    res_t              pending[$];
    int                errors;
    int                fired_total;

    function new();
      count = 0;
      serial = '0;
      limit = LIM_RESET;
      errors = 0;
      fired_total = 0;
    endfunction

    function logic [DL_W-1:0] sat(logic [DL_W-1:0] a, logic [DL_W-1:0] b);
      logic [DL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
    endfunction

    function void swap(int a, int b);
      logic [DL_W-1:0] d, v;
      logic [ID_W-1:0] i;
      logic [FLOW_W-1:0] f;
      logic r, n;
      d = h_dl[a]; v = h_iv[a]; i = h_id[a]; f = h_flow[a]; r = h_rep[a]; n = h_inl[a];
      h_dl[a] = h_dl[b]; h_iv[a] = h_iv[b]; h_id[a] = h_id[b];
      h_flow[a] = h_flow[b]; h_rep[a] = h_rep[b]; h_inl[a] = h_inl[b];
      h_dl[b] = d; h_iv[b] = v; h_id[b] = i; h_flow[b] = f; h_rep[b] = r; h_inl[b] = n;
    endfunction

    function int up(int s);
      int p;
      while (s > 0) begin
        p = (s - 1) / 2;
        if (h_dl[p] <= h_dl[s]) break;
        swap(p, s);
        s = p;
      end
      return s;
    endfunction

    function void down(int s);
      int k;
      forever begin
        k = s * 2 + 1;
        if (k >= count) break;
        if (k + 1 < count && h_dl[k+1] < h_dl[k]) k++;
        if (h_dl[s] <= h_dl[k]) break;
        swap(s, k);
        s = k;
      end
    endfunction

    function void drop(int s);
      count--;
      if (s < count) begin
        swap(s, count);
        down(up(s));
      end
    endfunction

    function int find(logic [ID_W-1:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < count; i++) if (h_id[i] == id) return i;
      return -1;
    endfunction

    function void push(logic [STAT_W-1:0] st, logic [ID_W-1:0] id, logic [FLOW_W-1:0] fl,
                       logic inl, logic wk, logic [DL_W-1:0] dl, logic lst);
      res_t r;
      r.status = st; r.id = id; r.flow = fl; r.inl = inl;
      r.wake = wk; r.dl = dl; r.last = lst;
      pending.push_back(r);
    endfunction

    function void note_cmd(logic [KIND_W-1:0] kind, logic [DL_W-1:0] now,
                           logic [DL_W-1:0] delay_raw, logic [ID_W-1:0] tid,
                           logic [FLOW_W-1:0] flow, logic rep, logic inl);
      logic [DL_W-1:0] dly, dl, nxt;
      int s, lim, fired;
      logic wk;
      dly = delay_raw[DL_W-1] ? '0 : delay_raw;
      case (kind)
        KIND_ADD: begin
          if (flow == 0) push(STAT_REJECT, 0, 0, 0, 0, 0, 1);
          else if (count >= HEAP_SLOTS) push(STAT_FULL, 0, 0, 0, 0, 0, 1);
          else begin
            serial++;
            if (serial == 0) serial = 1;
            dl = sat(now, dly);
            wk = (count == 0 || dl < h_dl[0]);
            s = count++;
            h_dl[s] = dl; h_iv[s] = dly; h_id[s] = serial; h_flow[s] = flow;
            h_rep[s] = rep; h_inl[s] = inl;
            void'(up(s));
            push(STAT_OK, serial, 0, 0, wk, 0, 1);
          end
        end
        KIND_CANCEL: begin
          s = find(tid);
          if (s >= 0) begin
            drop(s);
            push(STAT_OK, 0, 0, 0, 0, 0, 1);
          end else push(STAT_NOTFND, 0, 0, 0, 0, 0, 1);
        end
        KIND_REARM: begin
          s = find(tid);
          if (s >= 0) begin
            dl = sat(now, dly);
            wk = dl < h_dl[0];
            h_dl[s] = dl; h_iv[s] = dly;
            down(up(s));
            push(STAT_OK, 0, 0, 0, wk, 0, 1);
          end else push(STAT_NOTFND, 0, 0, 0, 0, 0, 1);
        end
        KIND_SWEEP: begin
          lim = limit;
          if (lim < 1) lim = 1;
          if (lim > SWEEP_MAX) lim = SWEEP_MAX;
          fired = 0;
          while (fired < lim && count > 0 && h_dl[0] <= now) begin
            push(STAT_FIRED, h_id[0], h_flow[0], h_inl[0], 0, 0, 0);
            if (h_rep[0]) begin
              nxt = sat(h_dl[0], h_iv[0]);
              if (nxt <= now) nxt = sat(now, 1);
              h_dl[0] = nxt;
              down(0);
            end else drop(0);
            fired++;
          end
          fired_total += fired;
          if (fired == 0) push(STAT_NOTHING, 0, 0, 0, 0, 0, 1);
          else pending[$].last = 1'b1;
        end
        KIND_QUERY: push(STAT_OK, 0, 0, 0, 0, count > 0 ? h_dl[0] : '0, 1);
        default: push(STAT_REJECT, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t mismatch expected %p actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LIM_W-1:0] cfg_wdata_i = '0;
  int cycles = 0;
  int n_cmds = 0;
  bit hold_off = 0;

  tdh_cmd_if cmd ();
  tdh_res_if res ();
  heap_scoreboard sb = new();

  timer_deadline_heap_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd(cmd.sink), .res(res.source),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0; cmd.kind = '0; cmd.now = '0; cmd.delay = '0;
    cmd.timer_id = '0; cmd.flow_id = '0; cmd.repeat_req = 1'b0;
    cmd.inline_callback = 1'b0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && res.valid && res.ready)
      sb.check_result('{res.status, res.result_id, res.result_flow, res.result_inline,
                        res.wake_needed, res.deadline_out, res.last});
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_off) res.ready <= 1'b0;
    else if (cycles % 97 < 20) res.ready <= 1'b1;
    else res.ready <= ($urandom_range(0, 3) != 0);
  end

  logic [DL_W-1:0] clock_now = 48'd1000;
  int burst = 0;

  task automatic send_cmd(logic [KIND_W-1:0] kind, logic [DL_W-1:0] now,
                          logic [DL_W-1:0] dly, logic [ID_W-1:0] tid,
                          logic [FLOW_W-1:0] flow, logic rep, logic inl);
    if (burst == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst = $urandom_range(1, 12);
    end
    burst--;
    cmd.valid = 1'b1; cmd.kind = kind; cmd.now = now; cmd.delay = dly;
    cmd.timer_id = tid; cmd.flow_id = flow; cmd.repeat_req = rep;
    cmd.inline_callback = inl;
    do @(posedge clk_i); while (!cmd.ready);
    sb.note_cmd(kind, now, dly, tid, flow, rep, inl);
    n_cmds++;
    @(negedge clk_i);
    cmd.valid = 1'b0;
  endtask

  task automatic drain();
    int t;
    t = 0;
    while (sb.pending.size() != 0 && t < 200000) begin
      @(negedge clk_i);
      t++;
    end
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = v;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return 0;
    if (sb.count > 0 && r < 8) return sb.h_id[$urandom_range(0, sb.count - 1)];
    return sb.serial - $urandom_range(0, 5);
  endfunction

  task automatic random_cmd(int add_weight);
    int r;
    logic [DL_W-1:0] dly, nw;
    r = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 40);
    nw = clock_now;
    if ($urandom_range(0, 30) == 0) nw = DL_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 9))
      0: dly = DL_W'({$urandom(), $urandom()});
      1: dly = 48'h7FFF_FFFF_FFFF;
      default: dly = DL_W'($urandom_range(0, 120));
    endcase
    if (r < add_weight)
      send_cmd(KIND_ADD, nw, dly, $urandom(),
               ($urandom_range(0, 15) == 0) ? '0 : FLOW_W'($urandom()),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (r < add_weight + 10)
      send_cmd(KIND_CANCEL, nw, dly, pick_id(), FLOW_W'($urandom()), 1'b0, 1'b0);
    else if (r < add_weight + 22)
      send_cmd(KIND_REARM, nw, dly, pick_id(), FLOW_W'($urandom()), 1'b1, 1'b1);
    else if (r < add_weight + 38)
      send_cmd(KIND_SWEEP, nw, dly, $urandom(), FLOW_W'($urandom()), 1'b0, 1'b0);
    else if (r < 97)
      send_cmd(KIND_QUERY, nw, dly, $urandom(), FLOW_W'($urandom()), 1'b0, 1'b0);
    else send_cmd(KIND_W'($urandom_range(5, 7)), nw, dly, $urandom(), FLOW_W'($urandom()),
                  1'b1, 1'b1);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed part
    send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_SWEEP, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
    send_cmd(KIND_ADD, 100, 0, 0, 16'h0000, 0, 0);
    send_cmd(KIND_ADD, 100, 48'h8000_0000_0000, 0, 16'hFFFF, 1, 1);
    send_cmd(KIND_ADD, 48'hFFFF_FFFF_FFF0, 48'h7FFF_FFFF_FFFF, 0, 16'h0001, 1, 0);
    send_cmd(KIND_ADD, 50, 10, 0, 16'h1234, 0, 1);
    send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CANCEL, 0, 0, 32'h0, 0, 0, 0);
    send_cmd(KIND_CANCEL, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_cmd(KIND_REARM, 20, 5, 32'd3, 0, 0, 0);
    send_cmd(KIND_REARM, 20, 5, 32'd99, 0, 0, 0);
    send_cmd(KIND_SWEEP, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
    send_cmd(KIND_CANCEL, 0, 0, 32'd3, 0, 0, 0);
    send_cmd(3'd5, 0, 0, 0, 0, 0, 0);
    send_cmd(3'd7, 0, 0, 0, 0, 1, 1);
    send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    write_limit(7'd0);
    send_cmd(KIND_SWEEP, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
    // fill the heap under a long receiver hold-off
    fork
      begin
        hold_off = 1;
        repeat (600) @(negedge clk_i);
        hold_off = 0;
      end
      repeat (70) send_cmd(KIND_ADD, clock_now, DL_W'($urandom_range(0, 200)), 0,
                           FLOW_W'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
    join
    write_limit(7'd127);
    repeat (60) random_cmd(20);
    write_limit(7'd1);
    repeat (50) random_cmd(40);
    write_limit(7'd3);
    repeat (50) random_cmd(40);
    write_limit(7'd64);
    repeat (50) random_cmd(35);
    drain();
    $display("ran %0d commands, %0d timers fired, sweep limits 0,127,1,3,64",
             n_cmds, sb.fired_total);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
